// ===== hw/rtl/lprt_pkg.sv =====
`default_nettype none
package lprt_pkg;

    // Table size default and fixed widths
    localparam int ENTRIES_DEF = 16;
    localparam int IDX_W = 8;
    localparam int ADDR_W = 128;
    localparam int MASK_BYTES = ADDR_W / 8;

    // Only the top 32 address bits are meaningful for IPv4.
    localparam logic [ADDR_W-1:0] V4_MASK = {32'hFFFF_FFFF, 96'h0};

    localparam logic [1:0] FAM_V4 = 2'd1;
    localparam logic [1:0] FAM_V6 = 2'd2;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_BAD    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_INVALID   = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_DONE
    } state_t;

    // Request broadcast to every cell during a scan
    typedef struct packed {
        logic              v6;
        logic [ADDR_W-1:0] dest;
        logic [7:0]        prefix;
    } req_bc_t;

    // Running record that travels down the cell chain
    typedef struct packed {
        logic              best_found;
        logic [7:0]        best_prefix;
        logic [31:0]       best_metric;
        logic [IDX_W-1:0]  best_idx;
        logic [7:0]        best_ifc;
        logic [ADDR_W-1:0] best_gw;
        logic              match_found;
        logic [IDX_W-1:0]  match_idx;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } scan_rec_t;

    // Write broadcast to the cells
    typedef struct packed {
        logic              en;
        logic              clear;
        logic [IDX_W-1:0]  idx;
        logic              v6;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [7:0]        prefix;
        logic [ADDR_W-1:0] gw;
        logic [7:0]        ifc;
        logic [31:0]       metric;
    } wr_bc_t;

    // A mask byte is well formed if it is a run of leading ones.
    function automatic logic byte_ok(input logic [7:0] b);
        logic [7:0] nb;
        nb = ~b;
        return (nb & (nb + 8'd1)) == 8'd0;
    endfunction

    function automatic logic [3:0] ones8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            n = n + {3'd0, b[k]};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lprt_cell.sv =====
`default_nettype none
module lprt_cell #(
    parameter int IDX = 0
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire lprt_pkg::req_bc_t    req,
    input  wire lprt_pkg::wr_bc_t     wr,
    input  wire                       in_v,
    input  wire lprt_pkg::scan_rec_t  in_rec,
    output logic                      out_v,
    output lprt_pkg::scan_rec_t       out_rec
);

    logic                          valid_reg;
    logic                          v6_reg;
    logic [lprt_pkg::ADDR_W-1:0]   dest_reg;
    logic [lprt_pkg::ADDR_W-1:0]   mask_reg;
    logic [7:0]                    prefix_reg;
    logic [lprt_pkg::ADDR_W-1:0]   gw_reg;
    logic [7:0]                    ifc_reg;
    logic [31:0]                   metric_reg;
    logic                          out_v_reg;
    lprt_pkg::scan_rec_t           out_rec_reg;
    lprt_pkg::scan_rec_t           rec_next;
    logic                          sel;
    logic                          hit_lkp;
    logic                          hit_exact;
    logic                          better;

    assign sel = wr.en && (wr.idx == lprt_pkg::IDX_W'(IDX));

    // Valid flag of the stored route
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel)
        begin
            valid_reg <= !wr.clear;
        end
    end

    // Route payload
    always_ff @(posedge clk)
    begin
        if (sel && !wr.clear)
        begin
            v6_reg     <= wr.v6;
            dest_reg   <= wr.dest;
            mask_reg   <= wr.mask;
            prefix_reg <= wr.prefix;
            gw_reg     <= wr.gw;
            ifc_reg    <= wr.ifc;
            metric_reg <= wr.metric;
        end
    end

    // Compare this entry against the request and update the record.
    always_comb
    begin
        hit_lkp   = valid_reg && (v6_reg == req.v6) && ((req.dest & mask_reg) == dest_reg);
        hit_exact = valid_reg && (v6_reg == req.v6) && (dest_reg == req.dest)
                    && (prefix_reg == req.prefix);
        better    = !in_rec.best_found || (prefix_reg > in_rec.best_prefix)
                    || ((prefix_reg == in_rec.best_prefix)
                        && (metric_reg < in_rec.best_metric));
        rec_next = in_rec;
        if (hit_lkp && better)
        begin
            rec_next.best_found  = 1'b1;
            rec_next.best_prefix = prefix_reg;
            rec_next.best_metric = metric_reg;
            rec_next.best_idx    = lprt_pkg::IDX_W'(IDX);
            rec_next.best_ifc    = ifc_reg;
            rec_next.best_gw     = gw_reg;
        end
        if (hit_exact && !in_rec.match_found)
        begin
            rec_next.match_found = 1'b1;
            rec_next.match_idx   = lprt_pkg::IDX_W'(IDX);
        end
        if (!valid_reg && !in_rec.free_found)
        begin
            rec_next.free_found = 1'b1;
            rec_next.free_idx   = lprt_pkg::IDX_W'(IDX);
        end
    end

    // Hand the record to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg <= rec_next;
    end

    assign out_v   = out_v_reg;
    assign out_rec = out_rec_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/longest_prefix_route_table_top.sv =====
// Longest-prefix route table with ENTRIES slots of IPv4 or IPv6 routes.
// Input items arrive on the s_ group: s_tuser carries the request kind
// (add, remove, lookup) and s_tdata the family, address, mask, gateway,
// interface and metric. Each item yields exactly one result item on the
// m_ group carrying status and, for a lookup, the matched route.
// The user must write the invalid interface number through
// cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce it.
// Flow: a lookup is scanned directly after accept; add and remove first
// check all 16 mask bytes one byte a cycle, then scan. A request rejected
// at accept goes straight to the result, and an add or remove with a
// malformed mask skips the scan. The scan is a row of cells, one per slot,
// that pass a running record along one cell a cycle, so one item is in
// work at a time: the next item is accepted once the result is registered.
// Reset empties the table and sets the invalid interface number to 255.
// A finished result waits in an output register; the next item is accepted
// meanwhile, and its result is held back until the waiting one is taken.
`default_nettype none
module longest_prefix_route_table_top #(
    parameter int ENTRIES = lprt_pkg::ENTRIES_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // family, dest_hi, dest_lo, mask_hi, mask_lo, gateway_in_hi,
    // gateway_in_lo, gateway_present, interface_in, metric_in
    input  wire  [431:0] s_tdata,
    // req_type
    input  wire  [1:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status, interface_out, gateway_out_hi, gateway_out_lo, metric_out,
    // prefix_out, entry_out
    output logic [183:0] m_tdata,
    input  wire          cfg_wr_en,
    input  wire  [7:0]   cfg_wr_data
);

    localparam int AW = lprt_pkg::ADDR_W;

    lprt_pkg::state_t      state_reg, state_next;
    lprt_pkg::req_kind_t   kind_reg;
    logic [7:0]            inv_id_reg;
    logic                  v6_reg;
    logic [AW-1:0]         dest_reg;
    logic [AW-1:0]         mask_sh_reg;
    logic [7:0]            prefix_reg;
    logic                  zero_seen_reg;
    logic                  bad_reg;
    logic [3:0]            byte_cnt_reg;
    logic [AW-1:0]         gw_reg;
    logic [7:0]            ifc_reg;
    logic [31:0]           metric_reg;
    logic                  go_reg;
    lprt_pkg::scan_rec_t   rec_reg;
    logic                  out_valid_reg;
    logic [183:0]          out_data_reg;

    // Decoded input fields
    logic [1:0]            in_fam;
    logic [AW-1:0]         in_dest, in_mask, in_gw;
    logic                  in_gpres;
    logic [7:0]            in_ifc;
    logic [31:0]           in_metric;
    logic                  in_v6, in_bad, accept;
    lprt_pkg::req_kind_t   in_kind;

    // Mask check step
    logic [7:0]            mbyte;
    logic                  step_bad;

    // Result assembly
    logic                  finish;
    lprt_pkg::status_t     res_status;
    logic [7:0]            res_ifc, res_prefix;
    logic [AW-1:0]         res_gw;
    logic [31:0]           res_metric;
    logic [lprt_pkg::IDX_W-1:0] res_idx;
    lprt_pkg::wr_bc_t      wr;
    lprt_pkg::req_bc_t     req;

    lprt_pkg::scan_rec_t   chain_rec [ENTRIES+1];
    logic                  chain_v   [ENTRIES+1];

    // Address-like fields are held as {bytes 0-7, bytes 8-15}.
    assign in_fam    = s_tdata[1:0];
    assign in_dest   = {s_tdata[65:2], s_tdata[129:66]};
    assign in_mask   = {s_tdata[193:130], s_tdata[257:194]};
    assign in_gw     = {s_tdata[321:258], s_tdata[385:322]};
    assign in_gpres  = s_tdata[386];
    assign in_ifc    = s_tdata[394:387];
    assign in_metric = s_tdata[426:395];
    assign in_kind   = lprt_pkg::req_kind_t'(s_tuser);
    assign in_v6     = (in_fam == lprt_pkg::FAM_V6);
    assign in_bad    = (in_kind == lprt_pkg::REQ_BAD)
                       || ((in_fam != lprt_pkg::FAM_V4) && (in_fam != lprt_pkg::FAM_V6))
                       || ((in_kind == lprt_pkg::REQ_ADD) && (in_ifc == inv_id_reg));

    assign s_tready = (state_reg == lprt_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_id_reg <= 8'hFF;
        end
        else if (cfg_wr_en)
        begin
            inv_id_reg <= cfg_wr_data;
        end
    end

    // One mask byte a cycle: leading ones, then only zero bytes.
    assign mbyte    = mask_sh_reg[AW-1:AW-8];
    assign step_bad = zero_seen_reg ? (mbyte != 8'd0) : !lprt_pkg::byte_ok(mbyte);

    // Request broadcast to the cells
    assign req.v6     = v6_reg;
    assign req.dest   = dest_reg;
    assign req.prefix = prefix_reg;

    // Cell chain
    assign chain_v[0]   = go_reg;
    assign chain_rec[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lprt_cell #(
            .IDX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .req    (req),
            .wr     (wr),
            .in_v   (chain_v[i]),
            .in_rec (chain_rec[i]),
            .out_v  (chain_v[i+1]),
            .out_rec(chain_rec[i+1])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        finish     = 1'b0;
        unique case (state_reg)
            lprt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_bad)
                    begin
                        state_next = lprt_pkg::S_DONE;
                    end
                    else if (in_kind == lprt_pkg::REQ_LOOKUP)
                    begin
                        state_next = lprt_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = lprt_pkg::S_PREP;
                    end
                end
            end
            lprt_pkg::S_PREP:
            begin
                if (byte_cnt_reg == 4'(lprt_pkg::MASK_BYTES - 1))
                begin
                    state_next = (bad_reg || step_bad) ? lprt_pkg::S_DONE : lprt_pkg::S_SCAN;
                end
            end
            lprt_pkg::S_SCAN:
            begin
                if (chain_v[ENTRIES])
                begin
                    state_next = lprt_pkg::S_DONE;
                end
            end
            lprt_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    finish     = 1'b1;
                    state_next = lprt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lprt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lprt_pkg::S_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next == lprt_pkg::S_SCAN) && (state_reg != lprt_pkg::S_SCAN);
        end
    end

    // Request capture and mask check
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= in_kind;
            v6_reg        <= in_v6;
            bad_reg       <= in_bad;
            zero_seen_reg <= 1'b0;
            prefix_reg    <= 8'd0;
            byte_cnt_reg  <= 4'd0;
            ifc_reg       <= in_ifc;
            metric_reg    <= in_metric;
            mask_sh_reg   <= in_v6 ? in_mask : (in_mask & lprt_pkg::V4_MASK);
            if (in_kind == lprt_pkg::REQ_LOOKUP)
            begin
                dest_reg <= in_v6 ? in_dest : (in_dest & lprt_pkg::V4_MASK);
            end
            else
            begin
                dest_reg <= in_v6 ? (in_dest & in_mask)
                                  : (in_dest & in_mask & lprt_pkg::V4_MASK);
            end
            if (!in_gpres)
            begin
                gw_reg <= '0;
            end
            else
            begin
                gw_reg <= in_v6 ? in_gw : (in_gw & lprt_pkg::V4_MASK);
            end
        end
        else if (state_reg == lprt_pkg::S_PREP)
        begin
            bad_reg       <= bad_reg || step_bad;
            zero_seen_reg <= zero_seen_reg || (mbyte != 8'hFF);
            prefix_reg    <= prefix_reg + {4'd0, lprt_pkg::ones8(mbyte)};
            mask_sh_reg   <= {mask_sh_reg[AW-9:0], 8'd0};
            byte_cnt_reg  <= byte_cnt_reg + 4'd1;
        end
        if ((state_reg == lprt_pkg::S_SCAN) && chain_v[ENTRIES])
        begin
            rec_reg <= chain_rec[ENTRIES];
        end
    end

    // Result and table write
    always_comb
    begin
        res_status = lprt_pkg::STS_OK;
        res_ifc    = 8'd0;
        res_gw     = '0;
        res_metric = 32'd0;
        res_prefix = 8'd0;
        res_idx    = '0;
        wr         = '0;
        wr.v6      = v6_reg;
        wr.dest    = dest_reg;
        wr.mask    = ~({AW{1'b1}} >> prefix_reg);
        wr.prefix  = prefix_reg;
        wr.gw      = gw_reg;
        wr.ifc     = ifc_reg;
        wr.metric  = metric_reg;
        if (bad_reg)
        begin
            res_status = lprt_pkg::STS_INVALID;
        end
        else
        begin
            priority case (kind_reg)
                lprt_pkg::REQ_LOOKUP:
                begin
                    if (rec_reg.best_found)
                    begin
                        res_ifc    = rec_reg.best_ifc;
                        res_gw     = rec_reg.best_gw;
                        res_metric = rec_reg.best_metric;
                        res_prefix = rec_reg.best_prefix;
                        res_idx    = rec_reg.best_idx;
                    end
                    else
                    begin
                        res_status = lprt_pkg::STS_NOT_FOUND;
                    end
                end
                lprt_pkg::REQ_REMOVE:
                begin
                    if (rec_reg.match_found)
                    begin
                        res_idx  = rec_reg.match_idx;
                        wr.en    = finish;
                        wr.clear = 1'b1;
                        wr.idx   = rec_reg.match_idx;
                    end
                    else
                    begin
                        res_status = lprt_pkg::STS_NOT_FOUND;
                    end
                end
                default:
                begin
                    if (rec_reg.match_found)
                    begin
                        res_idx = rec_reg.match_idx;
                        wr.en   = finish;
                        wr.idx  = rec_reg.match_idx;
                    end
                    else if (rec_reg.free_found)
                    begin
                        res_idx = rec_reg.free_idx;
                        wr.en   = finish;
                        wr.idx  = rec_reg.free_idx;
                    end
                    else
                    begin
                        res_status = lprt_pkg::STS_FULL;
                    end
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= {2'b00, res_idx[3:0], res_prefix, res_metric,
                             res_gw[63:0], res_gw[127:64], res_ifc, res_status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
